### sv/hhp_pkg.sv
// ----------------------------------------------------------------------------
// Hunk header parser package
// Shared constants, phase and status codes, and the request and result types
// used by the parser blocks.
// ----------------------------------------------------------------------------
package hhp_pkg;

   // Width of the parsed numbers and of the result fields.
   localparam int NUM_WIDTH   = 32;
   localparam int WIDE_WIDTH  = NUM_WIDTH + 4;
   localparam int OUT_WIDTH   = 32;

   // Number of leading bytes of a line that are skipped unchecked.
   localparam int PREFIX_SKIP = 4;
   localparam int SKIP_WIDTH  = 3;

   localparam int NUM_SLOTS   = 4;

   // Packed widths of the stream words.
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_FIELDS     = 2 + 4 * OUT_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELDS + 7) / 8) * 8;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_AT    = 8'h40;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SKIP,
      PH_OLD_START,
      PH_OLD_COUNT,
      PH_PLUS,
      PH_NEW_START,
      PH_NEW_COUNT,
      PH_AT1,
      PH_AT2,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_TRAILER   = 2'd2,
      ST_NONE      = 2'd3
   } status_type;

   typedef logic [NUM_WIDTH-1:0] num_type;
   typedef logic [OUT_WIDTH-1:0] out_num_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_start;
      logic       line_end;
   } req_item_type;

   typedef struct packed {
      out_num_type new_count;
      out_num_type new_start;
      out_num_type old_count;
      out_num_type old_start;
      logic [1:0]  status;
   } rsp_item_type;

   // Appends one decimal digit to a number, holding at the largest value.
   function automatic num_type add_digit(input num_type acc, input logic [3:0] digit);
      logic [WIDE_WIDTH-1:0] wide;
      wide = (WIDE_WIDTH'(acc) << 3) + (WIDE_WIDTH'(acc) << 1) + WIDE_WIDTH'(digit);
      if (wide > WIDE_WIDTH'({NUM_WIDTH{1'b1}})) begin
         add_digit = {NUM_WIDTH{1'b1}};
      end else begin
         add_digit = wide[NUM_WIDTH-1:0];
      end
   endfunction

   function automatic out_num_type to_out(input num_type value);
      to_out = OUT_WIDTH'(value);
   endfunction

endpackage

### sv/hhp_in_reg.sv
// ----------------------------------------------------------------------------
// Hunk header parser input register
// Holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module hhp_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  hhp_pkg::req_item_type req_item,
   input  logic                 step,
   output logic                 item_valid,
   output hhp_pkg::req_item_type item
);
   import hhp_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // A new word may enter while the held one is consumed in the same cycle.
   assign req_tready = !valid_ff || step;

   always_comb begin
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### sv/hhp_parser.sv
// ----------------------------------------------------------------------------
// Hunk header parser core
// Line state machine and number accumulator; one byte is handled per step.
// ----------------------------------------------------------------------------
module hhp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  hhp_pkg::req_item_type item,
   output logic                  has_result,
   output hhp_pkg::rsp_item_type result
);
   import hhp_pkg::*;

   phase_type                 phase_ff, phase_in;
   logic [SKIP_WIDTH-1:0]     skip_ff, skip_in;
   num_type                   acc_ff, acc_in;
   logic                      digit_ff, digit_in;
   num_type                   nums_ff [NUM_SLOTS];
   num_type                   nums_in [NUM_SLOTS];

   status_type                status;
   phase_type                 phase_next;
   logic                      ignore;
   logic                      is_digit;
   logic [SKIP_WIDTH-1:0]     skip_inc;
   logic [7:0]                c;

   assign c        = item.line_byte;
   assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);
   assign skip_inc = skip_ff + SKIP_WIDTH'(1);

   // Next phase and line status.
   always_comb begin
      status     = ST_NONE;
      phase_next = phase_ff;
      skip_in    = skip_ff;
      ignore     = 1'b0;
      if (item.line_start) begin
         skip_in    = SKIP_WIDTH'(1);
         phase_next = (PREFIX_SKIP <= 1) ? PH_OLD_START : PH_SKIP;
      end else begin
         unique case (phase_ff)
            PH_SKIP: begin
               skip_in = skip_inc;
               if (32'(skip_inc) >= 32'(PREFIX_SKIP)) begin
                  phase_next = PH_OLD_START;
               end
            end
            PH_OLD_START: begin
               if (!is_digit) begin
                  if (!digit_ff) status = ST_MALFORMED;
                  else if (c == CHAR_COMMA) phase_next = PH_OLD_COUNT;
                  else if (c == CHAR_SPACE) phase_next = PH_PLUS;
                  else status = ST_MALFORMED;
               end
            end
            PH_OLD_COUNT: begin
               if (!is_digit) begin
                  if (!digit_ff) status = ST_MALFORMED;
                  else if (c == CHAR_SPACE) phase_next = PH_PLUS;
                  else status = ST_MALFORMED;
               end
            end
            PH_PLUS: begin
               if (c == CHAR_PLUS) phase_next = PH_NEW_START;
               else status = ST_MALFORMED;
            end
            PH_NEW_START: begin
               if (!is_digit) begin
                  if (!digit_ff) status = ST_MALFORMED;
                  else if (c == CHAR_COMMA) phase_next = PH_NEW_COUNT;
                  else if (c == CHAR_SPACE) phase_next = PH_AT1;
                  else status = ST_TRAILER;
               end
            end
            PH_NEW_COUNT: begin
               if (!is_digit) begin
                  if (!digit_ff) status = ST_MALFORMED;
                  else if (c == CHAR_SPACE) phase_next = PH_AT1;
                  else status = ST_TRAILER;
               end
            end
            PH_AT1: begin
               if (c == CHAR_AT) phase_next = PH_AT2;
               else status = ST_TRAILER;
            end
            PH_AT2: begin
               status = (c == CHAR_AT) ? ST_OK : ST_TRAILER;
            end
            default: begin
               // Outside a line, bytes and their end marks are dropped.
               ignore = 1'b1;
            end
         endcase
      end
      if (!ignore && status == ST_NONE && item.line_end) begin
         status = ST_TRAILER;
      end
      has_result = !ignore && (status != ST_NONE);
      phase_in   = has_result ? PH_DONE : phase_next;
   end

   // Accumulator, stored numbers and result fields.
   always_comb begin
      acc_in   = acc_ff;
      digit_in = digit_ff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         nums_in[i] = nums_ff[i];
      end
      if (item.line_start) begin
         acc_in   = '0;
         digit_in = 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            nums_in[i] = '0;
         end
      end else begin
         case (phase_ff) inside
            PH_OLD_START, PH_OLD_COUNT, PH_NEW_START, PH_NEW_COUNT: begin
               if (is_digit) begin
                  acc_in   = add_digit(acc_ff, 4'(c - CHAR_0));
                  digit_in = 1'b1;
               end else if (digit_ff) begin
                  acc_in   = '0;
                  digit_in = 1'b0;
                  case (phase_ff)
                     PH_OLD_START: begin
                        nums_in[0] = acc_ff;
                        if (c != CHAR_COMMA) nums_in[1] = NUM_WIDTH'(1);
                     end
                     PH_OLD_COUNT: nums_in[1] = acc_ff;
                     PH_NEW_START: begin
                        nums_in[2] = acc_ff;
                        if (c != CHAR_COMMA) nums_in[3] = NUM_WIDTH'(1);
                     end
                     default: nums_in[3] = acc_ff;
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
      if (has_result) begin
         acc_in   = '0;
         digit_in = 1'b0;
      end
      result.status = status;
      if (status == ST_OK) begin
         result.old_start = to_out(nums_in[0]);
         result.old_count = to_out(nums_in[1]);
         result.new_start = to_out(nums_in[2]);
         result.new_count = to_out(nums_in[3]);
      end else begin
         result.old_start = '0;
         result.old_count = '0;
         result.new_start = '0;
         result.new_count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         skip_ff  <= '0;
         acc_ff   <= '0;
         digit_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            nums_ff[i] <= '0;
         end
      end else if (step) begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         acc_ff   <= acc_in;
         digit_ff <= digit_in;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            nums_ff[i] <= nums_in[i];
         end
      end
   end

endmodule

### sv/hhp_out_reg.sv
// ----------------------------------------------------------------------------
// Hunk header parser result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module hhp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hhp_pkg::rsp_item_type result,
   output logic                  can_load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output hhp_pkg::rsp_item_type rsp_item
);
   import hhp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

### sv/diff_hunk_header_parser_unit.sv
// Result path: the byte ending the line passes the input register, then the result
// register, before its result word is valid on rsp.
// Throughput: one byte per cycle while the result side keeps up; a held result word
// that rsp does not take stalls every byte. The per-byte path is one state update
// and a multiply-by-ten on the 32-bit accumulator between the two registers.
// Reset: synchronous, active high; the parser returns to idle and waits for a line start.
// ----------------------------------------------------------------------------
// Hunk header parser top level
// Parses a unified diff hunk header line, one byte per word, into its four
// numbers and a status.
// ----------------------------------------------------------------------------
module diff_hunk_header_parser_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hhp_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,  // [7:0] line_byte
   input  logic                                req_tuser,  // line_start
   input  logic                                req_tlast,  // line_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] status, [33:2] old_start, [65:34] old_count, [97:66] new_start,
   // [129:98] new_count, upper bits zero
   output logic [hhp_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);
   import hhp_pkg::*;

   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         item_valid;
   logic         can_load;
   logic         step;
   logic         has_result;

   assign req_item.line_byte  = req_tdata;
   assign req_item.line_start = req_tuser;
   assign req_item.line_end   = req_tlast;

   // A byte is consumed only when the result register can take what it produces.
   assign step = item_valid && can_load;

   hhp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   hhp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (item),
      .has_result (has_result),
      .result     (result)
   );

   hhp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step && has_result),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'(rsp_item);

endmodule
